// File: design/dsvm_pkg.sv
`timescale 1ns / 1ps

package dsvm_pkg;

  // operation codes on the input channel
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_NOTE_ON    = 3'd1;
  localparam logic [2:0] OP_SET_NOTE   = 3'd2;
  localparam logic [2:0] OP_WRITE_WORD = 3'd3;
  localparam logic [2:0] OP_SET_PARAMS = 3'd4;

  // lowest note that maps to slot zero
  localparam int NOTE_BASE = 60;

  // 0.7 as Q1.15
  localparam int MIX_SCALE = 22938;

  // slot field of a command covers the largest slot count
  localparam int CMD_SLOT_W = 5;

  // compare width wide enough for the largest slot size
  localparam int LIM_W = 21;

  // command kinds after decode
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_NOTE_ON,
    CMD_SET_NOTE,
    CMD_WRITE,
    CMD_PARAMS
  } cmd_kind_t;

  // one decoded request, as held in the command queue
  typedef struct packed {
    cmd_kind_t             kind;
    logic [1:0]            voice;
    logic [CMD_SLOT_W-1:0] slot;
    logic [14:0]           address;
    logic [15:0]           sample_word;
    logic [15:0]           sample_length;
    logic [15:0]           gain;
  } cmd_t;

  // gain of each slot after reset: 2.5, 0.5, 0.3 in Q4.12, then zero
  function automatic logic [15:0] slot_gain_reset(input int unsigned idx);
    logic [15:0] g;
    case (idx)
      0:       g = 16'd10240;
      1:       g = 16'd2048;
      2:       g = 16'd1229;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

// File: design/dsvm_ram.sv
`timescale 1ns / 1ps

module dsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/dsvm_front.sv
`timescale 1ns / 1ps

module dsvm_front #(
  parameter int NUM_VOICES     = 4,
  parameter int NUM_SLOTS      = 8,
  parameter int MAX_SLOT_WORDS = 32768
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [1:0]         voice,
  input  logic [6:0]         note,
  input  logic [2:0]         slot,
  input  logic [14:0]        address,
  input  logic signed [15:0] sample_word,
  input  logic [15:0]        sample_length,
  input  logic [15:0]        gain,
  input  logic               q_full,
  output logic               q_push,
  output dsvm_pkg::cmd_t     q_cmd
);

  import dsvm_pkg::*;

  logic       keep;
  logic       voice_ok;
  logic       slot_ok;
  logic       addr_ok;
  logic       note_ok;
  logic [6:0] note_off;

  // range checks
  always_comb begin
    note_off = note - 7'(NOTE_BASE);
    voice_ok = 5'(voice) < 5'(NUM_VOICES);
    slot_ok  = 6'(slot) < 6'(NUM_SLOTS);
    addr_ok  = LIM_W'(address) < LIM_W'(MAX_SLOT_WORDS);
    note_ok  = (note >= 7'(NOTE_BASE)) && (8'(note_off) < 8'(NUM_SLOTS));
  end

  // classify the request; ignored ones are taken and dropped
  always_comb begin
    q_cmd.voice         = voice;
    q_cmd.address       = address;
    q_cmd.sample_word   = sample_word;
    q_cmd.sample_length = sample_length;
    q_cmd.gain          = gain;
    q_cmd.slot          = CMD_SLOT_W'(slot);
    q_cmd.kind          = CMD_TICK;
    keep                = 1'b0;
    unique case (operation)
      OP_TICK: begin
        keep = 1'b1;
      end
      OP_NOTE_ON: begin
        q_cmd.kind = CMD_NOTE_ON;
        keep       = voice_ok;
      end
      OP_SET_NOTE: begin
        q_cmd.kind = CMD_SET_NOTE;
        q_cmd.slot = CMD_SLOT_W'(note_off);
        keep       = voice_ok && note_ok;
      end
      OP_WRITE_WORD: begin
        q_cmd.kind = CMD_WRITE;
        keep       = slot_ok && addr_ok;
      end
      OP_SET_PARAMS: begin
        q_cmd.kind = CMD_PARAMS;
        keep       = slot_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

// File: design/dsvm_queue.sv
`timescale 1ns / 1ps

module dsvm_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsvm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dsvm_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  import dsvm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign head_cmd = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/dsvm_back.sv
`timescale 1ns / 1ps

module dsvm_back #(
  parameter int NUM_VOICES     = 4,
  parameter int NUM_SLOTS      = 8,
  parameter int MAX_SLOT_WORDS = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  dsvm_pkg::cmd_t     cmd,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mix_out,
  output logic [3:0]         voices_active
);

  import dsvm_pkg::*;

  localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W   = $clog2(MAX_SLOT_WORDS + 1);
  localparam int DEPTH   = NUM_SLOTS * MAX_SLOT_WORDS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ACC_W   = 33 + VOICE_W;
  localparam int SCALE_W = ACC_W + 16;
  localparam int RND_SH  = 27;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL,
    ST_FLUSH,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  // slot parameters
  logic [15:0] slot_length [NUM_SLOTS];
  logic [15:0] slot_gain   [NUM_SLOTS];

  // voice state
  logic [NUM_VOICES-1:0] pending;
  logic [NUM_VOICES-1:0] playing;
  logic [SLOT_W-1:0]     next_slot [NUM_VOICES];
  logic [SLOT_W-1:0]     cur_slot  [NUM_VOICES];
  logic [POS_W-1:0]      position  [NUM_VOICES];

  // tick datapath
  logic [VOICE_W-1:0]        vi;
  logic                      hit_q;
  logic [15:0]               gain_q;
  logic signed [32:0]        prod;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SCALE_W-1:0] scaled;

  // lookup of the current voice
  logic              pend;
  logic              play_e;
  logic [SLOT_W-1:0] slot_e;
  logic [POS_W-1:0]  pos_e;
  logic [LIM_W-1:0]  len_raw;
  logic [LIM_W-1:0]  len_lim;
  logic              hit;

  // sample memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       ram_rdata;

  // rounding and saturation
  logic signed [SCALE_W-1:0] rnd;
  logic signed [SCALE_W-1:0] y;
  logic signed [15:0]        sat;
  logic [VOICE_W-1:0]        cmd_v;
  logic [SLOT_W-1:0]         cmd_s;

  assign cmd_v = VOICE_W'(cmd.voice);
  assign cmd_s = cmd.slot[SLOT_W-1:0];

  // pending note on takes effect first, then the end-of-slot check
  always_comb begin
    pend    = pending[vi];
    play_e  = playing[vi] | pend;
    slot_e  = pend ? next_slot[vi] : cur_slot[vi];
    pos_e   = pend ? '0 : position[vi];
    len_raw = LIM_W'(slot_length[slot_e]);
    len_lim = (len_raw > LIM_W'(MAX_SLOT_WORDS)) ? LIM_W'(MAX_SLOT_WORDS) : len_raw;
    hit     = play_e && (LIM_W'(pos_e) < len_lim);
    rd_addr = ADDR_W'(slot_e) * ADDR_W'(MAX_SLOT_WORDS) + ADDR_W'(pos_e);
    wr_addr = ADDR_W'(cmd_s) * ADDR_W'(MAX_SLOT_WORDS) + ADDR_W'(cmd.address);
  end

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign ram_we   = q_pop && (cmd.kind == CMD_WRITE);
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  dsvm_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.sample_word),
    .rdata (ram_rdata)
  );

  // round to nearest, ties up, then clamp to 16 bits
  always_comb begin
    rnd = scaled + SCALE_W'(1 << (RND_SH - 1));
    y   = rnd >>> RND_SH;
    if (y > SCALE_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (y < -SCALE_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = y[15:0];
    end
  end

  // the sequencer takes one command per cycle while idle; a tick walks the voices, a lookup and a multiply state each
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      playing   <= '0;
      vi        <= '0;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        next_slot[i] <= '0;
        cur_slot[i]  <= '0;
        position[i]  <= '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_length[i] <= '0;
        slot_gain[i]   <= slot_gain_reset(i);
      end
    end else begin
      prod_vld <= (state == ST_MUL) && hit_q;
      if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (cmd.kind)
              CMD_TICK: begin
                vi    <= '0;
                acc   <= '0;
                state <= ST_LOOKUP;
              end
              CMD_NOTE_ON: begin
                pending[cmd_v] <= 1'b1;
              end
              CMD_SET_NOTE: begin
                next_slot[cmd_v] <= cmd_s;
              end
              CMD_PARAMS: begin
                slot_length[cmd_s] <= cmd.sample_length;
                slot_gain[cmd_s]   <= cmd.gain;
              end
              default: begin
                // sample word writes go straight to the memory port
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          pending[vi]  <= 1'b0;
          playing[vi]  <= hit;
          cur_slot[vi] <= slot_e;
          position[vi] <= hit ? pos_e + 1'b1 : pos_e;
          gain_q       <= slot_gain[slot_e];
          hit_q        <= hit;
          state        <= ST_MUL;
        end
        ST_MUL: begin
          prod <= $signed(ram_rdata) * $signed({1'b0, gain_q});
          if (vi == VOICE_W'(NUM_VOICES - 1)) begin
            state <= ST_FLUSH;
          end else begin
            vi    <= vi + 1'b1;
            state <= ST_LOOKUP;
          end
        end
        ST_FLUSH: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          scaled <= SCALE_W'(acc) * SCALE_W'(MIX_SCALE);
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            mix_out       <= sat;
            voices_active <= 4'(playing);
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/drum_sample_voice_mixer.sv
`timescale 1ns / 1ps
// A tick taken by the back end visits each voice in a lookup and a multiply state, then
// flush, scale and emit; further commands wait until it is through, and a held result stalls.
// Other requests finish in the cycle the back end takes them from the queue.
// A 4-entry queue accepts one request a cycle while it has room.
// Reset: synchronous, clears voice state and slot lengths, loads the default slot gains;
// the sample memory is undefined until written and has no clearing pass.

module drum_sample_voice_mixer #(
  parameter int NUM_VOICES     = 4,
  parameter int NUM_SLOTS      = 8,
  parameter int MAX_SLOT_WORDS = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [1:0]         voice,
  input  logic [6:0]         note,
  input  logic [2:0]         slot,
  input  logic [14:0]        address,
  input  logic signed [15:0] sample_word,
  input  logic [15:0]        sample_length,
  input  logic [15:0]        gain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mix_out,
  output logic [3:0]         voices_active
);

  import dsvm_pkg::*;

  localparam logic [3:0] VOICE_MASK = 4'((17'd1 << NUM_VOICES) - 17'd1);

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // front: accept and decode
  dsvm_front #(
    .NUM_VOICES     (NUM_VOICES),
    .NUM_SLOTS      (NUM_SLOTS),
    .MAX_SLOT_WORDS (MAX_SLOT_WORDS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .voice         (voice),
    .note          (note),
    .slot          (slot),
    .address       (address),
    .sample_word   (sample_word),
    .sample_length (sample_length),
    .gain          (gain),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // command queue between the two halves
  dsvm_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: execute commands and mix voices
  dsvm_back #(
    .NUM_VOICES     (NUM_VOICES),
    .NUM_SLOTS      (NUM_SLOTS),
    .MAX_SLOT_WORDS (MAX_SLOT_WORDS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mix_out       (mix_out),
    .voices_active (voices_active)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_voice_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((voices_active & ~VOICE_MASK) == 4'b0))
    else $error("active bit set for a voice that does not exist");
`endif

endmodule
